>>> rtl/vpgc_pkg.sv
// Package for the planar VGA graphics controller: widths, register codes,
// configuration and command types, and the plane datapath functions.
// No dependencies.
package vpgc_pkg;

   // Video memory geometry
   localparam int PLANE_BYTES = 65536;
   localparam int ADDR_W      = $clog2(PLANE_BYTES);
   localparam int NUM_PLANES  = 4;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = NUM_PLANES * BYTE_W;

   // Configuration port widths and reset values
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam logic [BYTE_W-1:0] BIT_MASK_RESET = 8'hff;

   // Queue depths between the parts
   localparam int CMD_DEPTH   = 4;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH   = 2;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WRITE_MODE       = 3'd0,
      CSR_LOGIC_OP         = 3'd1,
      CSR_ROTATE_COUNT     = 3'd2,
      CSR_SET_RESET        = 3'd3,
      CSR_ENABLE_SET_RESET = 3'd4,
      CSR_BIT_MASK         = 3'd5,
      CSR_READ_PLANE       = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_AND  = 2'd1,
      OP_OR   = 2'd2,
      OP_XOR  = 2'd3
   } logic_op_type;

   typedef enum logic {
      WMODE_LOGIC = 1'b0,
      WMODE_LATCH = 1'b1
   } write_mode_type;

   typedef enum logic {
      REQ_READ  = 1'b0,
      REQ_WRITE = 1'b1
   } req_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ_WAIT
   } back_state_type;

   typedef struct packed {
      write_mode_type            write_mode;
      logic_op_type              logic_op;
      logic [2:0]                rotate_count;
      logic [NUM_PLANES-1:0]     set_reset;
      logic [NUM_PLANES-1:0]     enable_set_reset;
      logic [BYTE_W-1:0]         bit_mask;
      logic [1:0]                read_plane;
   } cfg_type;

   // Classified access; data is already rotated for mode 0
   typedef struct packed {
      req_kind_type              kind;
      logic [ADDR_W-1:0]         addr;
      logic [BYTE_W-1:0]         data;
   } cmd_type;

   // Rotate a byte right by n
   function automatic logic [BYTE_W-1:0] rotr8(input logic [BYTE_W-1:0] d,
                                               input logic [2:0] n);
      logic [2*BYTE_W-1:0] dbl;
      dbl = {d, d} >> n;
      return dbl[BYTE_W-1:0];
   endfunction

   // Byte of one plane out of a memory word
   function automatic logic [BYTE_W-1:0] plane_byte(input logic [WORD_W-1:0] w,
                                                    input logic [1:0] sel);
      logic [WORD_W-1:0] sh;
      sh = w >> {sel, 3'b000};
      return sh[BYTE_W-1:0];
   endfunction

   // Mode 0 write word: set/reset, logic op with the latch, bit mask
   function automatic logic [WORD_W-1:0] mode0_word(input logic [BYTE_W-1:0] rot,
                                                    input logic [WORD_W-1:0] latch,
                                                    input cfg_type cfg);
      logic [WORD_W-1:0] word;
      logic [BYTE_W-1:0] lat;
      logic [BYTE_W-1:0] d;
      word = '0;
      for (int i = 0; i < NUM_PLANES; i++) begin
         lat = latch[i*BYTE_W +: BYTE_W];
         d   = rot;
         if (cfg.enable_set_reset[i]) begin
            d = {BYTE_W{cfg.set_reset[i]}};
         end
         case (cfg.logic_op)
            OP_AND:  d = d & lat;
            OP_OR:   d = d | lat;
            OP_XOR:  d = d ^ lat;
            default: d = d;
         endcase
         word[i*BYTE_W +: BYTE_W] = (d & cfg.bit_mask) | (lat & ~cfg.bit_mask);
      end
      return word;
   endfunction

endpackage

>>> rtl/vpgc_front.sv
// Front end: takes request beats into an input stage, pre-rotates write data
// and hands classified commands to the command queue. Depends on vpgc_pkg.
module vpgc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_type,
   input  logic [15:0]                 req_address,
   input  logic [7:0]                  req_write_data,
   input  logic [2:0]                  rotate_count,
   output logic                        q_push,
   output vpgc_pkg::cmd_type           q_cmd,
   input  logic                        q_full
);
   import vpgc_pkg::*;

   logic    stage_valid_ff, stage_valid_in;
   cmd_type stage_cmd_ff, stage_cmd_in;
   logic    accept;
   logic    drain;

   // Stage drains whenever the queue has room
   assign drain  = stage_valid_ff && !q_full;
   assign full   = stage_valid_ff && q_full;
   assign accept = push && !full;
   assign q_push = drain;
   assign q_cmd  = stage_cmd_ff;

   // Classify the beat and rotate its data
   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_cmd_in   = stage_cmd_ff;
      if (drain) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in    = 1'b1;
         stage_cmd_in.kind = req_type ? REQ_WRITE : REQ_READ;
         stage_cmd_in.addr = req_address[ADDR_W-1:0];
         stage_cmd_in.data = rotr8(req_write_data, rotate_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_cmd_ff <= stage_cmd_in;
   end

endmodule

>>> rtl/vpgc_cmd_queue.sv
// Command queue between front and back end, a small register FIFO.
// Depends on vpgc_pkg.
module vpgc_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_push,
   input  vpgc_pkg::cmd_type   q_push_cmd,
   output logic                q_full,
   input  logic                q_pop,
   output vpgc_pkg::cmd_type   q_pop_cmd,
   output logic                q_empty
);
   import vpgc_pkg::*;

   cmd_type              entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign q_full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign q_empty   = (count_ff == '0);
   assign q_pop_cmd = entry_ff[rd_ptr_ff];
   assign do_push   = q_push && !q_full;
   assign do_pop    = q_pop && !q_empty;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push_cmd;
      end
   end

endmodule

>>> rtl/vpgc_back.sv
// Back end: four-plane video memory, the 32-bit latch, the write datapath
// and the result queue. Depends on vpgc_pkg.
module vpgc_back (
   input  logic                clock,
   input  logic                reset,
   input  vpgc_pkg::cfg_type   cfg,
   input  logic                q_empty,
   input  vpgc_pkg::cmd_type   q_cmd,
   output logic                q_pop,
   output logic                empty,
   input  logic                pop,
   output logic [7:0]          rsp_read_data
);
   import vpgc_pkg::*;

   // Video memory, one word per address, byte i is plane i
   logic [WORD_W-1:0]    mem [PLANE_BYTES];
   logic [WORD_W-1:0]    rd_word_ff;
   logic [WORD_W-1:0]    latch_ff, latch_in;

   back_state_type       state_ff, state_in;

   logic [BYTE_W-1:0]    rsp_entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] rsp_wr_ff, rsp_wr_in;
   logic [RSP_PTR_W-1:0] rsp_rd_ff, rsp_rd_in;
   logic [RSP_CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic                 start;
   logic                 mem_we, mem_re, latch_load;
   logic [WORD_W-1:0]    mem_wdata;
   logic                 rsp_push, rsp_pop;
   logic [BYTE_W-1:0]    rsp_push_data;

   // A command starts when idle and the result queue has a free slot
   assign start = (state_ff == BK_IDLE) && !q_empty
                  && (rsp_cnt_ff != RSP_CNT_W'(RSP_DEPTH));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (start && q_cmd.kind == REQ_READ) begin
               state_in = BK_READ_WAIT;
            end
         end
         BK_READ_WAIT: state_in = BK_IDLE;
         default:      state_in = BK_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      latch_load    = 1'b0;
      rsp_push      = 1'b0;
      rsp_push_data = '0;
      case (state_ff)
         BK_IDLE: begin
            if (start) begin
               q_pop = 1'b1;
               if (q_cmd.kind == REQ_WRITE) begin
                  mem_we   = 1'b1;
                  rsp_push = 1'b1;
               end else begin
                  mem_re = 1'b1;
               end
            end
         end
         BK_READ_WAIT: begin
            latch_load    = 1'b1;
            rsp_push      = 1'b1;
            rsp_push_data = plane_byte(rd_word_ff, cfg.read_plane);
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Write word: latch copy in mode 1, logic datapath in mode 0
   assign mem_wdata = (cfg.write_mode == WMODE_LATCH) ? latch_ff
                                                      : mode0_word(q_cmd.data, latch_ff, cfg);
   assign latch_in  = latch_load ? rd_word_ff : latch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         latch_ff <= '0;
      end else begin
         state_ff <= state_in;
         latch_ff <= latch_in;
      end
   end

   // Memory port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[q_cmd.addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_word_ff <= mem[q_cmd.addr];
      end
   end

   // Result queue
   assign empty         = (rsp_cnt_ff == '0);
   assign rsp_pop       = pop && !empty;
   assign rsp_read_data = rsp_entry_ff[rsp_rd_ff];

   always_comb begin
      rsp_wr_in  = rsp_push ? rsp_wr_ff + 1'b1 : rsp_wr_ff;
      rsp_rd_in  = rsp_pop  ? rsp_rd_ff + 1'b1 : rsp_rd_ff;
      rsp_cnt_in = rsp_cnt_ff;
      if (rsp_push && !rsp_pop) begin
         rsp_cnt_in = rsp_cnt_ff + 1'b1;
      end else if (rsp_pop && !rsp_push) begin
         rsp_cnt_in = rsp_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_wr_ff  <= '0;
         rsp_rd_ff  <= '0;
         rsp_cnt_ff <= '0;
      end else begin
         rsp_wr_ff  <= rsp_wr_in;
         rsp_rd_ff  <= rsp_rd_in;
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_entry_ff[rsp_wr_ff] <= rsp_push_data;
      end
   end

endmodule

>>> rtl/vga_planar_graphics_controller_top.sv
// Planar VGA graphics controller (write modes 0 and 1, read mode 0).
// Request side: push/full queue. An accepted beat is a read (req_type 0) or a
//   write (req_type 1) at req_address, with req_write_data for writes.
// Result side: empty/pop queue. Every request gives one beat on
//   rsp_read_data: the selected plane byte for a read, zero for a write.
// Configuration: csr_valid/csr_ready write channel, always ready; csr_index
//   picks the register, unknown indexes are ignored. Write only when idle.
// Path: an accepted request is registered in the front-end stage, then in the
//   command queue; a write result is queued as the write starts, a read result
//   once the registered memory word is there. Throughput: one write per cycle
//   while the result queue has room; reads do not overlap, since the registered
//   memory read must land in the latch before the next access starts.
// Reset clears the queues, the latch and the configuration registers (bit mask
//   to all ones); memory contents are undefined until written.
// When the receiver stalls, the result queue and then the command queue fill
//   and full rises; nothing is dropped.
// Depends on vpgc_pkg, vpgc_front, vpgc_cmd_queue, vpgc_back.
module vga_planar_graphics_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_type,
   input  logic [15:0]                         req_address,
   input  logic [7:0]                          req_write_data,
   output logic                                empty,
   input  logic                                pop,
   output logic [7:0]                          rsp_read_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vpgc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vpgc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import vpgc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_push_cmd, q_pop_cmd;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WRITE_MODE:       cfg_in.write_mode = write_mode_type'(csr_wdata[0]);
            CSR_LOGIC_OP:         cfg_in.logic_op = logic_op_type'(csr_wdata[1:0]);
            CSR_ROTATE_COUNT:     cfg_in.rotate_count = csr_wdata[2:0];
            CSR_SET_RESET:        cfg_in.set_reset = csr_wdata[NUM_PLANES-1:0];
            CSR_ENABLE_SET_RESET: cfg_in.enable_set_reset = csr_wdata[NUM_PLANES-1:0];
            CSR_BIT_MASK:         cfg_in.bit_mask = csr_wdata[BYTE_W-1:0];
            CSR_READ_PLANE:       cfg_in.read_plane = csr_wdata[1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.write_mode       <= WMODE_LOGIC;
         cfg_ff.logic_op         <= OP_NONE;
         cfg_ff.rotate_count     <= '0;
         cfg_ff.set_reset        <= '0;
         cfg_ff.enable_set_reset <= '0;
         cfg_ff.bit_mask         <= BIT_MASK_RESET;
         cfg_ff.read_plane       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end
   vpgc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rotate_count   (cfg_ff.rotate_count),
      .q_push         (q_push),
      .q_cmd          (q_push_cmd),
      .q_full         (q_full)
   );

   // Command queue
   vpgc_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .q_push     (q_push),
      .q_push_cmd (q_push_cmd),
      .q_full     (q_full),
      .q_pop      (q_pop),
      .q_pop_cmd  (q_pop_cmd),
      .q_empty    (q_empty)
   );

   // Back end
   vpgc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_empty       (q_empty),
      .q_cmd         (q_pop_cmd),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_read_data (rsp_read_data)
   );

endmodule

>>> sim/vga_planar_graphics_controller_top_tb.sv
// Testbench for vga_planar_graphics_controller_top: read/write beats with latch
// reuse, checked against a plane memory model held in a scoreboard class.
// Depends on vpgc_pkg and the controller RTL.
`timescale 1ns / 1ps

// Plane memory model: predicts the result byte of every accepted access
class plane_mem_scoreboard;
   bit [31:0] plane_words [bit [15:0]];
   bit [31:0] latch;
   vpgc_pkg::write_mode_type mode;
   vpgc_pkg::logic_op_type   op;
   bit [2:0] rotate;
   bit [3:0] fill;
   bit [3:0] fill_enable;
   bit [7:0] mask;
   bit [1:0] plane_sel;
   bit [7:0] expected_bytes [$];
   int failures;

   function new();
      mode        = vpgc_pkg::WMODE_LOGIC;
      op          = vpgc_pkg::OP_NONE;
      rotate      = '0;
      fill        = '0;
      fill_enable = '0;
      mask        = vpgc_pkg::BIT_MASK_RESET;
      plane_sel   = '0;
      latch       = '0;
      failures    = 0;
   endfunction

   // Register write; spare indexes are dropped
   function void set_register(bit [2:0] index, bit [7:0] value);
      case (index)
         vpgc_pkg::CSR_WRITE_MODE:       mode = vpgc_pkg::write_mode_type'(value[0]);
         vpgc_pkg::CSR_LOGIC_OP:         op = vpgc_pkg::logic_op_type'(value[1:0]);
         vpgc_pkg::CSR_ROTATE_COUNT:     rotate = value[2:0];
         vpgc_pkg::CSR_SET_RESET:        fill = value[3:0];
         vpgc_pkg::CSR_ENABLE_SET_RESET: fill_enable = value[3:0];
         vpgc_pkg::CSR_BIT_MASK:         mask = value;
         vpgc_pkg::CSR_READ_PLANE:       plane_sel = value[1:0];
         default: ;
      endcase
   endfunction

   // Word stored by a write in the logic datapath mode
   function bit [31:0] logic_write_word(bit [7:0] cpu_byte);
      bit [31:0] word;
      bit [7:0]  rot;
      bit [7:0]  lat;
      bit [7:0]  d;
      word = '0;
      for (int b = 0; b < 8; b++) rot[b] = cpu_byte[(b + rotate) % 8];
      for (int p = 0; p < 4; p++) begin
         lat = latch[8*p +: 8];
         d   = fill_enable[p] ? {8{fill[p]}} : rot;
         case (op)
            vpgc_pkg::OP_AND: d = d & lat;
            vpgc_pkg::OP_OR:  d = d | lat;
            vpgc_pkg::OP_XOR: d = d ^ lat;
            default: ;
         endcase
         word[8*p +: 8] = (d & mask) | (lat & ~mask);
      end
      return word;
   endfunction

   // Accepted request beat: update the memory and latch, queue the result byte
   function void note_access(vpgc_pkg::req_kind_type kind, bit [15:0] addr, bit [7:0] data);
      if (kind == vpgc_pkg::REQ_READ) begin
         latch = plane_words.exists(addr) ? plane_words[addr] : '0;
         expected_bytes.push_back(latch[8*plane_sel +: 8]);
      end else begin
         plane_words[addr] = (mode == vpgc_pkg::WMODE_LATCH) ? latch : logic_write_word(data);
         expected_bytes.push_back(8'h00);
      end
   endfunction

   // Accepted result beat against the oldest prediction
   function void check_result(bit [7:0] got);
      bit [7:0] want;
      if (expected_bytes.size() == 0) begin
         $display("%0t: result beat with none expected, got %02h", $time, got);
         failures++;
      end else begin
         want = expected_bytes.pop_front();
         if (got !== want) begin
            $display("%0t: read_data mismatch, expected %02h, got %02h", $time, want, got);
            failures++;
         end
      end
   endfunction
endclass

module vga_planar_graphics_controller_top_tb;
   import vpgc_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_type = 1'b0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   plane_mem_scoreboard sb;
   bit          tx_steady = 1'b0;
   bit          rx_steady = 1'b0;
   bit          written_set [bit [15:0]];
   bit [15:0]   written_list [$];

   vga_planar_graphics_controller_top dut (.*);

   always #1 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit [15:0] pick_written();
      return written_list[$urandom_range(0, written_list.size() - 1)];
   endfunction

   // Handshake monitors, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full)
            sb.note_access(req_kind_type'(req_type), req_address, req_write_data);
         if (pop && !empty)
            sb.check_result(rsp_read_data);
         if (csr_valid && csr_ready)
            sb.set_register(csr_index, csr_wdata);
      end
   end

   // Result side: random stalls, none while rx_steady is set
   initial begin
      int n;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         n = rx_steady ? 0 : gap_length();
         if (n > 0) begin
            pop <= 1'b0;
            repeat (n) @(posedge clock);
         end
         pop <= 1'b1;
      end
   end

   // One request beat, preceded by an optional gap; push is left high
   task automatic send_access(req_kind_type kind, bit [15:0] addr, bit [7:0] data);
      int g;
      g = tx_steady ? 0 : gap_length();
      if (g > 0) begin
         push <= 1'b0;
         repeat (g) @(posedge clock);
      end
      push           <= 1'b1;
      req_type       <= kind;
      req_address    <= addr;
      req_write_data <= data;
      if (kind == REQ_WRITE && !written_set.exists(addr)) begin
         written_set[addr] = 1'b1;
         written_list.push_back(addr);
      end
      do @(posedge clock); while (full);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending and let every outstanding result come back
   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      csr_index_type idx;
      int            items;
      int            r;
      bit [15:0]     a;
      bit [7:0]      v;

      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: extreme addresses and data
      send_access(REQ_WRITE, 16'h0000, 8'h00);
      send_access(REQ_WRITE, 16'hffff, 8'hff);
      send_access(REQ_READ,  16'hffff, 8'h00);
      send_access(REQ_READ,  16'h0000, 8'hff);
      wait_idle();

      // Largest rotate, partial set/reset, XOR, low-nibble mask, top plane
      write_register(CSR_ROTATE_COUNT, 8'h07);
      write_register(CSR_ENABLE_SET_RESET, 8'h05);
      write_register(CSR_SET_RESET, 8'h0f);
      write_register(CSR_LOGIC_OP, {6'b0, OP_XOR});
      write_register(CSR_BIT_MASK, 8'h0f);
      write_register(CSR_READ_PLANE, 8'h03);
      send_access(REQ_READ,  16'hffff, 8'h00);
      send_access(REQ_WRITE, 16'h1234, 8'h81);
      send_access(REQ_READ,  16'h1234, 8'h00);
      wait_idle();

      // Latch copy mode; upper data bits must be masked off
      write_register(CSR_WRITE_MODE, 8'hff);
      write_register(CSR_READ_PLANE, 8'hfd);
      send_access(REQ_READ,  16'h1234, 8'h00);
      send_access(REQ_WRITE, 16'h8000, 8'h5a);
      send_access(REQ_READ,  16'h8000, 8'h00);
      wait_idle();

      // AND with no rotate and full mask
      write_register(CSR_WRITE_MODE, {7'b0, WMODE_LOGIC});
      write_register(CSR_LOGIC_OP, {6'b0, OP_AND});
      write_register(CSR_ROTATE_COUNT, 8'h00);
      write_register(CSR_ENABLE_SET_RESET, 8'hf0);
      write_register(CSR_BIT_MASK, 8'hff);
      write_register(CSR_READ_PLANE, 8'h02);
      send_access(REQ_READ,  16'hffff, 8'h00);
      send_access(REQ_WRITE, 16'h0001, 8'h3c);
      send_access(REQ_READ,  16'h0001, 8'h00);
      wait_idle();

      // Unknown index is ignored; OR with empty mask keeps the latch
      write_register(CSR_SPARE_INDEX, 8'hff);
      write_register(CSR_LOGIC_OP, {6'b0, OP_OR});
      write_register(CSR_ENABLE_SET_RESET, 8'h0f);
      write_register(CSR_SET_RESET, 8'h00);
      write_register(CSR_BIT_MASK, 8'h00);
      write_register(CSR_READ_PLANE, 8'h00);
      send_access(REQ_READ,  16'h1234, 8'h00);
      send_access(REQ_WRITE, 16'h0002, 8'h00);
      send_access(REQ_READ,  16'h0002, 8'h00);
      wait_idle();

      // Random phases: fresh settings, then mostly read-modify-write beats
      repeat (16) begin
         idx = idx.first();
         repeat (idx.num()) begin
            r = $urandom_range(0, 3);
            v = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom_range(0, 255));
            write_register(idx, v);
            idx = idx.next();
         end
         if ($urandom_range(0, 3) == 0)
            write_register(CSR_SPARE_INDEX, 8'($urandom_range(0, 255)));
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);

         items = 0;
         while (items < 80) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
               a = pick_written();
               send_access(REQ_READ, a, 8'($urandom_range(0, 255)));
               if ($urandom_range(0, 1)) a = 16'($urandom_range(0, 65535));
               send_access(REQ_WRITE, a, 8'($urandom_range(0, 255)));
               items += 2;
            end else if (r < 7) begin
               send_access(REQ_WRITE, 16'($urandom_range(0, 65535)),
                           8'($urandom_range(0, 255)));
               items += 1;
            end else if (r < 9) begin
               send_access(REQ_READ, pick_written(), 8'($urandom_range(0, 255)));
               items += 1;
            end else begin
               // one latch load feeding two writes
               send_access(REQ_READ, pick_written(), 8'($urandom_range(0, 255)));
               send_access(REQ_WRITE, pick_written(), 8'($urandom_range(0, 255)));
               send_access(REQ_WRITE, 16'($urandom_range(0, 65535)),
                           8'($urandom_range(0, 255)));
               items += 3;
            end
         end
         wait_idle();
         tx_steady = 1'b0;
         rx_steady = 1'b0;
      end

      if (sb.failures == 0)
         $display("[vga_planar_graphics_controller_top] OK");
      else
         $display("[vga_planar_graphics_controller_top] ERROR");
      $finish;
   end

   // Run limit
   initial begin
      #2000000;
      $display("[vga_planar_graphics_controller_top] ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/vpgc_pkg.sv
rtl/vpgc_front.sv
rtl/vpgc_cmd_queue.sv
rtl/vpgc_back.sv
rtl/vga_planar_graphics_controller_top.sv
sim/vga_planar_graphics_controller_top_tb.sv
